/* hw/rtl/psmd_pkg.sv */
// Package: shared types, constants and helpers for the PS/2 mouse packet decoder.
`default_nettype none

package psmd_pkg;

	localparam int COORD_WIDTH = 12;
	localparam int COORD_LIMIT = (1 << COORD_WIDTH) - 1;
	localparam int POS_W       = 12;
	localparam int WHEEL_W     = 15;
	localparam int CFG_DATA_W  = 12;
	localparam int CFG_IDX_W   = 2;
	localparam int NUM_EVENTS  = 5;

	localparam logic [7:0] HDR_SYNC_MASK = 8'hC0;
	localparam logic [7:0] HDR_X_SIGN    = 8'h10;
	localparam logic [7:0] HDR_Y_SIGN    = 8'h20;
	localparam logic [7:0] HDR_BTN_MASK  = 8'h07;

	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_MAX      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX      = 2'd2;

	localparam logic [CFG_DATA_W-1:0] X_MAX_RESET = 12'd1024;
	localparam logic [CFG_DATA_W-1:0] Y_MAX_RESET = 12'd768;

	typedef enum logic [2:0] {
		EV_MOVE        = 3'd0,
		EV_LEFT_DOWN   = 3'd1,
		EV_LEFT_UP     = 3'd2,
		EV_RIGHT_DOWN  = 3'd3,
		EV_RIGHT_UP    = 3'd4,
		EV_MIDDLE_DOWN = 3'd5,
		EV_MIDDLE_UP   = 3'd6,
		EV_WHEEL       = 3'd7
	} ev_kind_t;

	typedef enum logic [1:0] {
		POS_HEADER = 2'd0,
		POS_XMOT   = 2'd1,
		POS_YMOT   = 2'd2,
		POS_WHEEL  = 2'd3
	} byte_pos_t;

	typedef struct packed {
		logic                  wheel_mode;
		logic [CFG_DATA_W-1:0] x_max;
		logic [CFG_DATA_W-1:0] y_max;
	} cfg_t;

	// event mask order: move, left, right, middle, wheel
	typedef struct packed {
		logic [NUM_EVENTS-1:0]     mask;
		logic [COORD_WIDTH-1:0]    x;
		logic [COORD_WIDTH-1:0]    y;
		logic [2:0]                btn;
		logic signed [WHEEL_W-1:0] wheel;
	} pkt_t;

	function automatic logic [COORD_WIDTH-1:0] clamp_coord(
		input logic signed [COORD_WIDTH+1:0] v,
		input logic [CFG_DATA_W-1:0]         maxv
	);
		logic [COORD_WIDTH-1:0] hi;
		if (int'(maxv) > COORD_LIMIT) begin
			hi = COORD_WIDTH'(COORD_LIMIT);
		end else begin
			hi = COORD_WIDTH'(maxv);
		end
		if (v < 0) begin
			return '0;
		end else if (v > signed'({2'b00, hi})) begin
			return hi;
		end else begin
			return v[COORD_WIDTH-1:0];
		end
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/psmd_framer.sv */
// Packet framer: byte position, motion and pointer state, event set of a finished packet.
`default_nettype none

module psmd_framer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire psmd_pkg::cfg_t cfg,
	input  wire logic           byte_valid,
	input  wire logic [7:0]     byte_data,
	input  wire logic           advance,
	output logic                finish,
	output psmd_pkg::pkt_t      pkt
);
	import psmd_pkg::*;

	byte_pos_t              pos_q, pos_d;
	logic [7:0]             hdr_q, xm_q, ym_q;
	logic [COORD_WIDTH-1:0] ptr_x_q, ptr_y_q;
	logic [2:0]             prev_btn_q;

	logic [7:0]                ym;
	logic signed [8:0]         dx;
	logic signed [9:0]         dy;
	logic signed [7:0]         dz;
	logic signed [WHEEL_W-1:0] wz;
	logic                      moved;
	logic [2:0]                btn, chg;
	logic signed [COORD_WIDTH+1:0] sum_x, sum_y;
	logic                      hdr_ok;

	assign hdr_ok = (byte_data & HDR_SYNC_MASK) == 8'h00;

	always_comb begin
		pos_d = pos_q;
		case (pos_q)
			POS_HEADER: if (hdr_ok) begin
				pos_d = POS_XMOT;
			end
			POS_XMOT:   pos_d = POS_YMOT;
			POS_YMOT:   pos_d = cfg.wheel_mode ? POS_WHEEL : POS_HEADER;
			POS_WHEEL:  pos_d = POS_HEADER;
			default:    pos_d = POS_HEADER;
		endcase
	end

	always_comb begin
		finish = byte_valid &&
			((pos_q == POS_YMOT && !cfg.wheel_mode) || pos_q == POS_WHEEL);
		ym     = (pos_q == POS_YMOT) ? byte_data : ym_q;
		dx     = signed'({((hdr_q & HDR_X_SIGN) != 8'h00), xm_q});
		dy     = -10'(signed'({((hdr_q & HDR_Y_SIGN) != 8'h00), ym}));
		dz     = (pos_q == POS_WHEEL) ? signed'(byte_data) : 8'sd0;
		wz     = WHEEL_W'(dz);
		moved  = (dx != 9'sd0) || (dy != 10'sd0);
		btn    = 3'(hdr_q & HDR_BTN_MASK);
		chg    = btn ^ prev_btn_q;
		sum_x  = signed'({2'b00, ptr_x_q}) + (COORD_WIDTH+2)'(dx);
		sum_y  = signed'({2'b00, ptr_y_q}) + (COORD_WIDTH+2)'(dy);

		pkt.x     = moved ? clamp_coord(sum_x, cfg.x_max) : ptr_x_q;
		pkt.y     = moved ? clamp_coord(sum_y, cfg.y_max) : ptr_y_q;
		pkt.btn   = btn;
		pkt.wheel = (wz <<< 7) - (wz <<< 3);
		pkt.mask  = {dz != 8'sd0, chg, moved};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_HEADER;
			hdr_q      <= '0;
			xm_q       <= '0;
			ym_q       <= '0;
			ptr_x_q    <= '0;
			ptr_y_q    <= '0;
			prev_btn_q <= '0;
		end else if (advance) begin
			pos_q <= pos_d;
			case (pos_q)
				POS_HEADER: if (hdr_ok) begin
					hdr_q <= byte_data;
				end
				POS_XMOT:   xm_q <= byte_data;
				POS_YMOT:   ym_q <= byte_data;
				default:    ;
			endcase
			if (finish) begin
				ptr_x_q    <= pkt.x;
				ptr_y_q    <= pkt.y;
				prev_btn_q <= pkt.btn;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ps2_mouse_packet_decoder_top.sv */
// PS/2 mouse packet decoder top level: config registers, input stage, event set and output register.
// Raw mouse bytes enter a one-deep input register and are framed into 3-byte packets, or
// 4-byte packets when wheel_mode is set; headers with bits 7:6 not both zero are dropped.
// A byte that does not complete a packet moves on in the cycle after it is taken, so such
// bytes are taken one per cycle. The completing byte turns into a set of up to five events
// (move, left, right and middle button changes, wheel), which then leave through the output
// register at one event per cycle while out_stall is low; the completing byte of the next
// packet waits in the input register until the previous packet's last event has entered the
// output register. A completing byte passes from the input register into the pending event
// set, and from there each event moves into the output register. Every event carries the
// pointer position after its packet, and last_event marks the final event of each packet.
`default_nettype none

module ps2_mouse_packet_decoder_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [psmd_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [psmd_pkg::CFG_DATA_W-1:0]   wr_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [7:0]                        rx_byte,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [2:0]                             event_kind,
	output logic [psmd_pkg::POS_W-1:0]             pos_x,
	output logic [psmd_pkg::POS_W-1:0]             pos_y,
	output logic signed [psmd_pkg::WHEEL_W-1:0]    wheel_amount,
	output logic [2:0]                             button_bits,
	output logic                                   last_event
);
	import psmd_pkg::*;

	cfg_t cfg_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance, finish;
	pkt_t       pkt;

	logic [NUM_EVENTS-1:0]     pend_mask_q;
	logic [COORD_WIDTH-1:0]    pend_x_q, pend_y_q;
	logic [2:0]                pend_btn_q;
	logic signed [WHEEL_W-1:0] pend_wheel_q;

	logic                      out_valid_q;
	ev_kind_t                  kind_q;
	logic [POS_W-1:0]          pos_x_q, pos_y_q;
	logic signed [WHEEL_W-1:0] wheel_q;
	logic [2:0]                btn_q;
	logic                      last_q;

	logic                  load_out;
	logic [NUM_EVENTS-1:0] pop, mask_after;
	ev_kind_t              kind_d;
	logic signed [WHEEL_W-1:0] wheel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wheel_mode <= 1'b0;
			cfg_q.x_max      <= X_MAX_RESET;
			cfg_q.y_max      <= Y_MAX_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_WHEEL_MODE: cfg_q.wheel_mode <= wr_data[0];
				CFG_X_MAX:      cfg_q.x_max      <= wr_data;
				CFG_Y_MAX:      cfg_q.y_max      <= wr_data;
				default:        ;
			endcase
		end
	end

	// input stage
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	psmd_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (valid_s1),
		.byte_data  (byte_s1),
		.advance    (advance),
		.finish     (finish),
		.pkt        (pkt)
	);

	// pick the lowest pending event for the output register
	always_comb begin
		load_out = (pend_mask_q != '0) && (!out_valid_q || !out_stall);
		pop      = load_out ? (pend_mask_q & (~pend_mask_q + NUM_EVENTS'(1))) : '0;
		mask_after = pend_mask_q & ~pop;
		advance  = valid_s1 && (!finish || mask_after == '0);

		kind_d  = EV_MOVE;
		wheel_d = '0;
		case (pop)
			5'b00001: kind_d = EV_MOVE;
			5'b00010: kind_d = pend_btn_q[0] ? EV_LEFT_DOWN : EV_LEFT_UP;
			5'b00100: kind_d = pend_btn_q[1] ? EV_RIGHT_DOWN : EV_RIGHT_UP;
			5'b01000: kind_d = pend_btn_q[2] ? EV_MIDDLE_DOWN : EV_MIDDLE_UP;
			5'b10000: begin
				kind_d  = EV_WHEEL;
				wheel_d = pend_wheel_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_mask_q <= '0;
		end else if (advance && finish) begin
			pend_mask_q <= pkt.mask;
		end else begin
			pend_mask_q <= mask_after;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && finish) begin
			pend_x_q     <= pkt.x;
			pend_y_q     <= pkt.y;
			pend_btn_q   <= pkt.btn;
			pend_wheel_q <= pkt.wheel;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q  <= kind_d;
			pos_x_q <= POS_W'(pend_x_q);
			pos_y_q <= POS_W'(pend_y_q);
			wheel_q <= wheel_d;
			btn_q   <= pend_btn_q;
			last_q  <= (mask_after == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = kind_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign wheel_amount = wheel_q;
	assign button_bits  = btn_q;
	assign last_event   = last_q;

`ifndef ASSERT_OFF
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_event |-> pend_mask_q != '0)
		else $error("non-final event delivered with no event pending");

	a_wheel_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wheel_amount != '0 |-> event_kind == EV_WHEEL)
		else $error("wheel amount on a non-wheel event");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance && finish |-> mask_after == '0)
		else $error("packet finished while events still pending");
`endif

endmodule

`default_nettype wire

/* dv/psmd_event_scoreboard_pkg.sv */
// Scoreboard for the mouse packet decoder: event predictor and queue of expected events.
package psmd_event_scoreboard_pkg;

	import psmd_pkg::*;

	typedef struct {
		ev_kind_t                  kind;
		logic [POS_W-1:0]          x;
		logic [POS_W-1:0]          y;
		logic signed [WHEEL_W-1:0] wheel;
		logic [2:0]                buttons;
		logic                      last;
	} mouse_event_t;

	class mouse_event_scoreboard;

		logic                  wheel_mode;
		logic [CFG_DATA_W-1:0] x_max;
		logic [CFG_DATA_W-1:0] y_max;

		byte_pos_t        position;
		logic [7:0]       header;
		logic [7:0]       x_motion;
		logic [7:0]       y_motion;
		logic [POS_W-1:0] ptr_x;
		logic [POS_W-1:0] ptr_y;
		logic [2:0]       prev_buttons;

		mouse_event_t expected_events[$];
		int           errors;

		function new();
			wheel_mode   = 1'b0;
			x_max        = X_MAX_RESET;
			y_max        = Y_MAX_RESET;
			position     = POS_HEADER;
			header       = '0;
			x_motion     = '0;
			y_motion     = '0;
			ptr_x        = '0;
			ptr_y        = '0;
			prev_buttons = '0;
			errors       = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
			case (index)
				CFG_WHEEL_MODE: wheel_mode = value[0];
				CFG_X_MAX:      x_max = value;
				CFG_Y_MAX:      y_max = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_events.size();
		endfunction

		function logic [POS_W-1:0] saturate(int v, logic [CFG_DATA_W-1:0] maxv);
			int hi;
			hi = int'(maxv);
			if (hi > COORD_LIMIT) hi = COORD_LIMIT;
			if (v < 0) return '0;
			if (v > hi) return POS_W'(hi);
			return POS_W'(v);
		endfunction

		function void complete_packet(logic [7:0] wheel_byte, bit has_wheel);
			int           dx;
			int           dy;
			int           dz;
			logic [2:0]   btn;
			logic [2:0]   changed;
			mouse_event_t ev;
			mouse_event_t burst[$];
			ev_kind_t     down_kind[3];
			ev_kind_t     up_kind[3];
			down_kind = '{EV_LEFT_DOWN, EV_RIGHT_DOWN, EV_MIDDLE_DOWN};
			up_kind   = '{EV_LEFT_UP, EV_RIGHT_UP, EV_MIDDLE_UP};
			dx = int'(x_motion) - (((header & HDR_X_SIGN) != 0) ? 256 : 0);
			dy = (((header & HDR_Y_SIGN) != 0) ? 256 : 0) - int'(y_motion);
			dz = has_wheel ? int'($signed(wheel_byte)) : 0;
			btn = 3'(header & HDR_BTN_MASK);
			changed = btn ^ prev_buttons;
			if (dx != 0 || dy != 0) begin
				ptr_x = saturate(int'(ptr_x) + dx, x_max);
				ptr_y = saturate(int'(ptr_y) + dy, y_max);
			end
			ev.x       = ptr_x;
			ev.y       = ptr_y;
			ev.buttons = btn;
			ev.wheel   = '0;
			ev.last    = 1'b0;
			if (dx != 0 || dy != 0) begin
				ev.kind = EV_MOVE;
				burst.push_back(ev);
			end
			for (int i = 0; i < 3; i++) begin
				if (changed[i]) begin
					ev.kind = btn[i] ? down_kind[i] : up_kind[i];
					burst.push_back(ev);
				end
			end
			if (dz != 0) begin
				ev.kind  = EV_WHEEL;
				ev.wheel = WHEEL_W'(dz * 120);
				burst.push_back(ev);
			end
			foreach (burst[i]) begin
				ev      = burst[i];
				ev.last = (i == burst.size() - 1);
				expected_events.push_back(ev);
			end
			prev_buttons = btn;
			position     = POS_HEADER;
		endfunction

		function void note_byte(logic [7:0] b);
			case (position)
				POS_HEADER: begin
					if ((b & HDR_SYNC_MASK) == 0) begin
						header   = b;
						position = POS_XMOT;
					end
				end
				POS_XMOT: begin
					x_motion = b;
					position = POS_YMOT;
				end
				POS_YMOT: begin
					y_motion = b;
					if (wheel_mode) position = POS_WHEEL;
					else complete_packet(8'h00, 1'b0);
				end
				default: complete_packet(b, 1'b1);
			endcase
		endfunction

		function void check_event(mouse_event_t got);
			mouse_event_t want;
			if (expected_events.size() == 0) begin
				errors++;
				$display("%0t unexpected event: kind=%0d x=%0d y=%0d wheel=%0d btn=%0d last=%0d",
					$time, got.kind, got.x, got.y, got.wheel, got.buttons, got.last);
				return;
			end
			want = expected_events.pop_front();
			if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
					got.wheel !== want.wheel || got.buttons !== want.buttons ||
					got.last !== want.last) begin
				errors++;
				$display("%0t mismatch: expected kind=%0d x=%0d y=%0d wheel=%0d btn=%0d last=%0d",
					$time, want.kind, want.x, want.y, want.wheel, want.buttons, want.last);
				$display("%0t            actual kind=%0d x=%0d y=%0d wheel=%0d btn=%0d last=%0d",
					$time, got.kind, got.x, got.y, got.wheel, got.buttons, got.last);
			end
		endfunction

	endclass

endpackage

/* dv/ps2_mouse_packet_decoder_top_test.sv */
// Testbench top: drives mouse bytes and register writes into the decoder and checks its events.
module ps2_mouse_packet_decoder_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	import psmd_pkg::*;
	import psmd_event_scoreboard_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            rx_byte = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            event_kind;
	logic [POS_W-1:0]      pos_x;
	logic [POS_W-1:0]      pos_y;
	logic signed [WHEEL_W-1:0] wheel_amount;
	logic [2:0]            button_bits;
	logic                  last_event;

	mouse_event_scoreboard board;

	bit         gaps_on = 1'b1;
	int         burst_left = 4;
	int         hold_request = 0;
	int         hold_count = 0;
	int         pattern_left = 0;
	int         busy_percent = 0;
	logic       gen_wheel_mode = 1'b0;
	logic [2:0] gen_buttons = '0;

	ps2_mouse_packet_decoder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_kind  (event_kind),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.wheel_amount(wheel_amount),
		.button_bits (button_bits),
		.last_event  (last_event)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_count   = hold_request;
			hold_request = 0;
		end
		if (hold_count > 0) begin
			hold_count--;
			out_stall <= 1'b1;
		end else begin
			if (pattern_left == 0) begin
				pattern_left = $urandom_range(20, 120);
				case ($urandom_range(0, 3))
					0: busy_percent = 0;
					1: busy_percent = 25;
					2: busy_percent = 50;
					default: busy_percent = 80;
				endcase
			end
			pattern_left--;
			out_stall <= ($urandom_range(0, 99) < busy_percent);
		end
	end

	always @(negedge clk) begin : watch
		mouse_event_t got;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			got.kind    = ev_kind_t'(event_kind);
			got.x       = pos_x;
			got.y       = pos_y;
			got.wheel   = wheel_amount;
			got.buttons = button_bits;
			got.last    = last_event;
			board.check_event(got);
		end
	end

	task automatic offer_byte(input logic [7:0] b);
		bit taken;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		board.note_byte(b);
		if (gaps_on) begin
			if (burst_left <= 1) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 10);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic offer_bytes(input logic [7:0] seq[$]);
		foreach (seq[i]) offer_byte(seq[i]);
	endtask

	// drain every expected event, then let the block finish any quiet work
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_config(input logic wm, input logic [CFG_DATA_W-1:0] xm,
			input logic [CFG_DATA_W-1:0] ym);
		wr_en    <= 1'b1;
		wr_index <= CFG_WHEEL_MODE;
		wr_data  <= CFG_DATA_W'(wm);
		@(posedge clk);
		board.set_register(CFG_WHEEL_MODE, CFG_DATA_W'(wm));
		wr_index <= CFG_X_MAX;
		wr_data  <= xm;
		@(posedge clk);
		board.set_register(CFG_X_MAX, xm);
		wr_index <= CFG_Y_MAX;
		wr_data  <= ym;
		@(posedge clk);
		board.set_register(CFG_Y_MAX, ym);
		wr_en <= 1'b0;
		gen_wheel_mode = wm;
	endtask

	function automatic logic [8:0] pick_motion();
		int v;
		case ($urandom_range(0, 4))
			0: return 9'd0;
			1, 2: begin
				v = $urandom_range(0, 8) - 4;
				return 9'(v);
			end
			default: return 9'($urandom);
		endcase
	endfunction

	task automatic send_random_packets(input int count);
		int         sent;
		int         r;
		logic [8:0] dx;
		logic [8:0] dy;
		logic [7:0] hdr;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				offer_byte(8'($urandom));
			end else if (r < 16) begin
				offer_byte({2'($urandom_range(1, 3)), 6'($urandom)});
			end else begin
				if ($urandom_range(0, 1) == 0) gen_buttons = 3'($urandom);
				dx  = pick_motion();
				dy  = pick_motion();
				hdr = {2'b00, dy[8], dx[8], 1'($urandom), gen_buttons};
				offer_byte(hdr);
				offer_byte(dx[7:0]);
				offer_byte(dy[7:0]);
				sent += 3;
				if (gen_wheel_mode) begin
					offer_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
					sent++;
				end
			end
		end
	endtask

	initial begin : stimulus
		logic [7:0] seq[$];
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		seq = '{8'hC8, 8'h40, 8'h80,
			8'h09, 8'h7F, 8'h80,
			8'h1F, 8'h00, 8'h00,
			8'h0F, 8'h00, 8'h00,
			8'h38, 8'hFF, 8'hFF};
		offer_bytes(seq);
		settle();
		write_config(1'b1, 12'd4095, 12'd0);
		seq = '{8'h09, 8'h01, 8'h01, 8'h80,
			8'h0E, 8'h05, 8'h00, 8'h7F,
			8'h08, 8'h00, 8'h00};
		offer_bytes(seq);
		settle();
		// switch mode with a packet waiting on its fourth byte
		write_config(1'b0, 12'd1024, 12'd768);
		offer_byte(8'h01);
		settle();

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: write_config(1'b0, 12'd4095, 12'd4095);
				1: write_config(1'b1, 12'd0, 12'd0);
				2: write_config(1'b1, 12'($urandom), 12'($urandom));
				3: write_config(1'b0, 12'd20, 12'd10);
				4: write_config(1'b1, 12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)));
				5: write_config(1'b0, 12'($urandom), 12'($urandom));
				default: write_config(1'b1, 12'd4095, 12'd0);
			endcase
			if (p == 2) begin
				hold_request = 150;
				gaps_on      = 1'b0;
			end
			send_random_packets(45);
			gaps_on = 1'b1;
			settle();
		end

		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* ps2_mouse_packet_decoder_top.f */
hw/rtl/psmd_pkg.sv
hw/rtl/psmd_framer.sv
hw/rtl/ps2_mouse_packet_decoder_top.sv
dv/psmd_event_scoreboard_pkg.sv
dv/ps2_mouse_packet_decoder_top_test.sv
